// File: sv/uam_pkg.sv
// Shared types and constants for the acknowledge frame matcher.
package uam_pkg;

  localparam int unsigned FRAME_LEN = 10;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned ELAPSED_W = 17;
  localparam int unsigned TIMEOUT_W = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd3000;

  // fixed part of the acknowledge frame
  localparam logic [7:0] SYNC_1    = 8'hB5;
  localparam logic [7:0] SYNC_2    = 8'h62;
  localparam logic [7:0] ACK_CLASS = 8'h05;
  localparam logic [7:0] ACK_ID    = 8'h01;
  localparam logic [7:0] LEN_LO    = 8'h02;
  localparam logic [7:0] LEN_HI    = 8'h00;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_WAIT    = 2'd1,
    ST_ACK     = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACK_CLASS = 2'd0,
    CFG_ACK_IDENT = 2'd1,
    CFG_TIMEOUT   = 2'd2
  } cfg_idx_t;

endpackage

// File: sv/uam_if.sv
// Valid/ready channel interfaces for the matcher's request and result words.
interface uam_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

interface uam_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] match_count;

  modport source (output valid, output status, output match_count, input ready);
  modport sink   (input valid, input status, input match_count, output ready);
endinterface

// File: sv/uam_expect.sv
// Expected frame byte at a given position, check bytes derived from class and id.
module uam_expect
  import uam_pkg::*;
(
  input  logic [POS_W-1:0] pos,
  input  logic [7:0]       ack_class,
  input  logic [7:0]       ack_ident,
  output logic [7:0]       exp_byte
);

  logic [7:0] ck_a;
  logic [7:0] ck_b;

  // Fletcher over 05 01 02 00 cls id; constant partial sums folded in
  assign ck_a = 8'd8 + ack_class + ack_ident;
  assign ck_b = 8'd43 + {ack_class[6:0], 1'b0} + ack_ident;

  always_comb begin
    case (pos)
      4'd0:    exp_byte = SYNC_1;
      4'd1:    exp_byte = SYNC_2;
      4'd2:    exp_byte = ACK_CLASS;
      4'd3:    exp_byte = ACK_ID;
      4'd4:    exp_byte = LEN_LO;
      4'd5:    exp_byte = LEN_HI;
      4'd6:    exp_byte = ack_class;
      4'd7:    exp_byte = ack_ident;
      4'd8:    exp_byte = ck_a;
      4'd9:    exp_byte = ck_b;
      default: exp_byte = 8'h00;
    endcase
  end

endmodule

// File: sv/ubx_ack_matcher_core.sv
// Acknowledge frame matcher: one request word in, one result word out.
// The result word of an accepted request is registered and shows in the next cycle.
// Throughput: 1 word per cycle while the result side is ready; the result register frees in the cycle it is taken.
// Reset (rst, synchronous): status idle, match count and tick count zero,
// class and id zero, timeout 3000 ticks, no result pending.
module ubx_ack_matcher_core
  import uam_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  uam_req_if.sink               req,
  uam_rsp_if.source             rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [7:0]           ack_class;
  logic [7:0]           ack_ident;
  logic [TIMEOUT_W-1:0] timeout_ticks;

  status_t              phase, phase_next;
  logic [POS_W-1:0]     match_pos, match_pos_next;
  logic [ELAPSED_W-1:0] elapsed, elapsed_next;

  logic                 rsp_valid;
  status_t              rsp_status;
  logic [POS_W-1:0]     rsp_count;

  logic                 accept;
  logic [7:0]           exp_byte;
  logic [POS_W-1:0]     pos_inc;
  logic [ELAPSED_W-1:0] elapsed_inc;

  uam_expect u_expect (
    .pos       (match_pos),
    .ack_class (ack_class),
    .ack_ident (ack_ident),
    .exp_byte  (exp_byte)
  );

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ack_class     <= '0;
      ack_ident     <= '0;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ACK_CLASS: ack_class     <= cfg_data[7:0];
        CFG_ACK_IDENT: ack_ident     <= cfg_data[7:0];
        CFG_TIMEOUT:   timeout_ticks <= cfg_data[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  assign pos_inc     = match_pos + POS_W'(1);
  assign elapsed_inc = (&elapsed) ? elapsed : elapsed + ELAPSED_W'(1);

  always_comb begin
    phase_next     = phase;
    match_pos_next = match_pos;
    elapsed_next   = elapsed;
    case (op_t'(req.operation))
      OP_START: begin
        phase_next     = ST_WAIT;
        match_pos_next = '0;
        elapsed_next   = '0;
      end
      OP_BYTE: begin
        if (phase == ST_WAIT) begin
          // a mismatching byte restarts the search and is not rechecked
          if (req.rx_byte == exp_byte) begin
            match_pos_next = pos_inc;
            if (pos_inc == POS_W'(FRAME_LEN)) begin
              phase_next = ST_ACK;
            end
          end else begin
            match_pos_next = '0;
          end
        end
      end
      OP_TICK: begin
        if (phase == ST_WAIT) begin
          elapsed_next = elapsed_inc;
          if (elapsed_inc > {1'b0, timeout_ticks}) begin
            phase_next = ST_TIMEOUT;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= ST_IDLE;
      match_pos <= '0;
      elapsed   <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      match_pos <= match_pos_next;
      elapsed   <= elapsed_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_status <= phase_next;
      rsp_count  <= match_pos_next;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.status      = rsp_status;
  assign rsp.match_count = rsp_count;

endmodule

// File: sv/uam_checker.sv
// Port-level checks for the matcher, bound to the top level.
module uam_checker
  import uam_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic [1:0] req_operation,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [1:0] rsp_status,
  input logic [3:0] rsp_match_count
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result pending right after reset");

  a_start_result: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_operation == OP_START) |=>
      (rsp_valid && rsp_status == ST_WAIT && rsp_match_count == 4'd0))
    else $error("start word did not give a cleared waiting result");

  a_ack_full: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status == ST_ACK) |-> rsp_match_count == 4'(FRAME_LEN))
    else $error("acknowledged without a full frame match");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status == ST_IDLE) |-> rsp_match_count == 4'd0)
    else $error("idle result with nonzero match count");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_status) && $stable(rsp_match_count)))
    else $error("stalled result word changed");

endmodule

bind ubx_ack_matcher_core uam_checker u_uam_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .req_operation   (req.operation),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_match_count (rsp.match_count)
);

// File: test/ubx_ack_matcher_core_tb.sv
// Testbench for the acknowledge frame matcher: random traffic checked against a predictor.
`timescale 1ns / 100ps

module ubx_ack_matcher_core_tb;
  import uam_pkg::*;

  localparam logic [1:0] OP_RSVD    = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int EPISODES       = 40;

  typedef struct packed {
    status_t    status;
    logic [3:0] count;
  } ack_word_t;

  // Tracks matcher state and holds the result words still owed by the block.
  class ack_scoreboard;
    logic [7:0]  cls_reg;
    logic [7:0]  ident_reg;
    logic [15:0] timeout_reg;
    logic [3:0]  pos;
    logic [ELAPSED_W-1:0] ticks;
    status_t     phase;
    ack_word_t   expected_q[$];
    int          mismatches;
    int          checked;
    int          arms;
    int          acks;
    int          timeouts;

    function new();
      cls_reg     = '0;
      ident_reg   = '0;
      timeout_reg = TIMEOUT_RESET;
      pos         = '0;
      ticks       = '0;
      phase       = ST_IDLE;
      mismatches  = 0;
      checked     = 0;
      arms        = 0;
      acks        = 0;
      timeouts    = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_ACK_CLASS: cls_reg = data[7:0];
        CFG_ACK_IDENT: ident_reg = data[7:0];
        CFG_TIMEOUT:   timeout_reg = data;
        default: ;
      endcase
    endfunction

    function logic [7:0] frame_byte(int unsigned at);
      logic [7:0] hdr [6];
      logic [7:0] sum_a;
      logic [7:0] sum_b;
      hdr = '{ACK_CLASS, ACK_ID, LEN_LO, LEN_HI, cls_reg, ident_reg};
      sum_a = '0;
      sum_b = '0;
      foreach (hdr[i]) begin
        sum_a = sum_a + hdr[i];
        sum_b = sum_b + sum_a;
      end
      case (at)
        0: return SYNC_1;
        1: return SYNC_2;
        2, 3, 4, 5, 6, 7: return hdr[at-2];
        8: return sum_a;
        9: return sum_b;
        default: return 8'h00;
      endcase
    endfunction

    function void note_request(logic [1:0] op, logic [7:0] b);
      ack_word_t w;
      if (op == OP_START) begin
        phase = ST_WAIT;
        pos   = '0;
        ticks = '0;
        arms++;
      end else if (op == OP_BYTE && phase == ST_WAIT) begin
        // a mismatching byte restarts the hunt and is not tried as a sync byte
        if (pos < FRAME_LEN && b == frame_byte(32'(pos))) pos = pos + 4'd1;
        else pos = '0;
        if (pos >= FRAME_LEN) begin
          pos   = 4'(FRAME_LEN);
          phase = ST_ACK;
          acks++;
        end
      end else if (op == OP_TICK && phase == ST_WAIT) begin
        if (ticks != '1) ticks = ticks + ELAPSED_W'(1);
        if (ticks > timeout_reg) begin
          phase = ST_TIMEOUT;
          timeouts++;
        end
      end
      w.status = phase;
      w.count  = pos;
      expected_q.push_back(w);
    endfunction

    function void check_result(logic [1:0] st, logic [3:0] cnt);
      ack_word_t w;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: status %0d count %0d", st, cnt);
        return;
      end
      w = expected_q.pop_front();
      if (st !== w.status || cnt !== w.count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result word %0d: expected status %0d count %0d, got status %0d count %0d",
                   checked, w.status, w.count, st, cnt);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    quiet = 1'b1;
  bit                    hold_request = 1'b0;
  int                    stuck = 0;
  ack_scoreboard         sb;

  uam_req_if req ();
  uam_rsp_if rsp ();

  ubx_ack_matcher_core dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // mostly no gap, some short ones, a few long
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: bursts of ready with random stalls, plus one long hold when asked.
  initial begin
    int gap;
    rsp.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        rsp.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      rsp.ready = 1'b1;
      repeat ($urandom_range(1, 24)) @(negedge clk);
      gap = idle_gap();
      if (gap != 0) begin
        rsp.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  // Result check first, then the new request, so a word never meets its own expectation.
  always @(posedge clk) begin
    if (rst) begin
      stuck = 0;
    end else begin
      if (rsp.valid && rsp.ready) sb.check_result(rsp.status, rsp.match_count);
      if (req.valid && req.ready) sb.note_request(req.operation, req.rx_byte);
      if ((rsp.valid && rsp.ready) || (req.valid && req.ready)) stuck = 0;
      else stuck++;
      if (stuck >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", stuck);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // All driving tasks start and end on a falling edge.
  task automatic send_word(input logic [1:0] op, input logic [7:0] b);
    int gap;
    gap = idle_gap();
    if (gap != 0) begin
      req.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid     = 1'b1;
    req.operation = op;
    req.rx_byte   = b;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_quiet();
    req.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    sb.set_register(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // One arm followed by n words: mostly the awaited frame, with breaks, ticks and noise.
  task automatic run_episode(input int noise, input int n);
    logic [7:0] frame [FRAME_LEN];
    logic [7:0] b;
    int j;
    int r;
    foreach (frame[k]) frame[k] = sb.frame_byte(k);
    send_word(OP_START, 8'($urandom));
    j = 0;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < noise) begin
        b = (r % 3 == 0) ? SYNC_1 : 8'($urandom);
        send_word(OP_BYTE, b);
        j = (b == frame[j]) ? j + 1 : 0;
      end else if (r < noise + 15) begin
        send_word(OP_TICK, 8'($urandom));
      end else if (r < noise + 18) begin
        send_word(OP_RSVD, 8'($urandom));
      end else if (r < noise + 20) begin
        send_word(OP_START, 8'($urandom));
        j = 0;
      end else begin
        send_word(OP_BYTE, frame[j]);
        j = j + 1;
      end
      if (j == FRAME_LEN) j = 0;
    end
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'h00;
    if (r < 30) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] pick_timeout();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'($urandom_range(2, 6));
      3: return 16'hFFFF;
      4: return TIMEOUT_RESET;
      5: return 16'($urandom);
      default: return 16'($urandom_range(3, 12));
    endcase
  endfunction

  initial begin
    sb = new();
    rst           = 1'b1;
    req.valid     = 1'b0;
    req.operation = OP_START;
    req.rx_byte   = 8'h00;
    cfg_we        = 1'b0;
    cfg_index     = CFG_ACK_CLASS;
    cfg_data      = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // idle: bytes, ticks and reserved ops leave the status alone
    send_word(OP_BYTE, SYNC_1);
    send_word(OP_TICK, 8'hFF);
    send_word(OP_RSVD, 8'hAA);
    // full frame with reset class and id
    send_word(OP_START, 8'h55);
    for (int k = 0; k < FRAME_LEN; k++) send_word(OP_BYTE, sb.frame_byte(k));
    send_word(OP_BYTE, 8'h00);
    send_word(OP_TICK, 8'h00);
    // rearm after ack; a sync byte that breaks the frame is not taken as a new start
    send_word(OP_START, 8'h00);
    send_word(OP_BYTE, SYNC_1);
    send_word(OP_BYTE, SYNC_2);
    send_word(OP_BYTE, SYNC_1);
    send_word(OP_BYTE, SYNC_2);
    wait_quiet();
    write_reg(CFG_TIMEOUT, 16'd0);
    write_reg(CFG_UNUSED, 16'hFFFF);
    // zero timeout: first tick gives up
    send_word(OP_START, 8'hFF);
    send_word(OP_RSVD, 8'h00);
    send_word(OP_TICK, 8'h0F);
    send_word(OP_BYTE, SYNC_1);

    for (int ep = 0; ep < EPISODES; ep++) begin
      quiet = (ep < 4) || (ep == 20);
      wait_quiet();
      if (ep == 1) begin
        write_reg(CFG_ACK_CLASS, 16'h0000);
        write_reg(CFG_ACK_IDENT, 16'hFFFF);
        write_reg(CFG_TIMEOUT, 16'hFFFF);
      end else if (ep == 2) begin
        write_reg(CFG_ACK_CLASS, 16'hFFFF);
        write_reg(CFG_ACK_IDENT, 16'h0000);
        write_reg(CFG_TIMEOUT, 16'h0000);
      end else begin
        write_reg(CFG_ACK_CLASS, {8'($urandom), pick_byte()});
        write_reg(CFG_ACK_IDENT, {8'($urandom), pick_byte()});
        write_reg(CFG_TIMEOUT, pick_timeout());
      end
      // long output stall while words keep coming, so the input backs up
      if (ep == 20) begin
        hold_request = 1'b1;
        run_episode(3, 60);
      end else begin
        run_episode((ep % 2 != 0) ? 3 : 20, $urandom_range(11, 21));
      end
    end
    wait_quiet();

    $display("checked %0d result words over %0d arms: %0d frames acknowledged, %0d timeouts",
             sb.checked, sb.arms, sb.acks, sb.timeouts);
    $display("covered register extremes, broken frames, idle and reserved words, %0d-cycle stall",
             HOLD_CYCLES);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/uam_pkg.sv
sv/uam_if.sv
sv/uam_expect.sv
sv/ubx_ack_matcher_core.sv
sv/uam_checker.sv
test/ubx_ack_matcher_core_tb.sv
